[src/fwpi_pkg.sv]
// Shared types and codes for the priority-insert queue.
// Used by the top level fifo_with_priority_insert; no dependencies.
package fwpi_pkg;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_RD,
		S_CHK,
		S_TAIL
	} state_t;

	typedef struct packed {
		logic signed [15:0] prio;
		logic signed [31:0] data;
	} entry_t;

	localparam int ENTRY_W = 48;

endpackage

[src/fwpi_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module fwpi_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/fifo_with_priority_insert.sv]
// Bounded queue of (data, priority) items with append, insert-by-priority and remove-head.
// Depends on fwpi_pkg and fwpi_ram.
//
// Entries live in one circular RAM (registered read). Append completes from IDLE; remove
// reads the head in IDLE and returns it from HEAD. A priority insert walks the queue from
// the head, through RD and CHK per stored entry: it finds the first entry with strictly
// greater priority, then moves each later entry one slot up, carrying the displaced one.
// One item is in flight at a time; a new item is taken once the previous result is gone.
// An append or insert into a full queue and a remove on an empty one are flagged in tuser.
module fifo_with_priority_insert #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // in_data[31:0], in_priority[47:32]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_data[31:0], out_priority[47:32], fill[52:48], zero
	output logic [1:0]  m_tuser    // status[1:0]
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fwpi_pkg::state_t state_q, state_d;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q, idx_q;
	logic          found_q;
	fwpi_pkg::entry_t carry_q, new_e, rd_e;
	logic signed [15:0] new_prio_q;

	logic        m_valid_q;
	logic [1:0]  status_q;
	logic [31:0] odata_q;
	logic [15:0] oprio_q;
	logic [4:0]  fill_q;

	logic          accept, full, empty;
	fwpi_pkg::func_t fn;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	fwpi_pkg::entry_t wdata;
	logic [fwpi_pkg::ENTRY_W-1:0] rdata;
	logic          lt, last;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, h} + (AW+1)'(i);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign fn       = fwpi_pkg::func_t'(s_tuser);
	assign s_tready = (state_q == fwpi_pkg::S_IDLE) && !m_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign new_e    = fwpi_pkg::entry_t'(s_tdata[47:0] & 48'hFFFF_FFFF_FFFF);
	assign rd_e     = fwpi_pkg::entry_t'(rdata);
	assign lt       = new_prio_q < rd_e.prio;
	assign last     = (idx_q + CW'(1)) == count_q;

	fwpi_ram #(.WIDTH(fwpi_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwpi_pkg::S_IDLE: begin
				if (accept && fn == fwpi_pkg::FN_REMOVE && !empty) begin
					state_d = fwpi_pkg::S_HEAD;
				end else if (accept && fn == fwpi_pkg::FN_INSERT && !full && !empty) begin
					state_d = fwpi_pkg::S_RD;
				end
			end
			fwpi_pkg::S_HEAD: state_d = fwpi_pkg::S_IDLE;
			fwpi_pkg::S_RD:   state_d = fwpi_pkg::S_CHK;
			fwpi_pkg::S_CHK:  state_d = last ? fwpi_pkg::S_TAIL : fwpi_pkg::S_RD;
			fwpi_pkg::S_TAIL: state_d = fwpi_pkg::S_IDLE;
			default:          state_d = fwpi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = phys(head_q, count_q);
		wdata = new_e;
		raddr = phys(head_q, idx_q);
		unique case (state_q)
			fwpi_pkg::S_IDLE: begin
				raddr = head_q;
				if (accept && !full &&
				    (fn == fwpi_pkg::FN_APPEND || (fn == fwpi_pkg::FN_INSERT && empty))) begin
					we = 1'b1;
				end
			end
			fwpi_pkg::S_CHK: begin
				waddr = phys(head_q, idx_q);
				wdata = carry_q;
				we    = found_q || lt;
			end
			fwpi_pkg::S_TAIL: begin
				waddr = phys(head_q, idx_q);
				wdata = carry_q;
				we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fwpi_pkg::S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				fwpi_pkg::S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if ((fn == fwpi_pkg::FN_APPEND || fn == fwpi_pkg::FN_INSERT) && !full &&
						    (fn == fwpi_pkg::FN_APPEND || empty)) begin
							count_q   <= count_q + CW'(1);
							m_valid_q <= 1'b1;
						end else if ((fn == fwpi_pkg::FN_APPEND || fn == fwpi_pkg::FN_INSERT)
						             && full) begin
							m_valid_q <= 1'b1;
						end else if (fn == fwpi_pkg::FN_REMOVE && empty) begin
							m_valid_q <= 1'b1;
						end else if (fn == fwpi_pkg::FN_NONE) begin
							m_valid_q <= 1'b1;
						end
					end
				end
				fwpi_pkg::S_HEAD: begin
					head_q    <= phys(head_q, CW'(1));
					count_q   <= count_q - CW'(1);
					m_valid_q <= 1'b1;
				end
				fwpi_pkg::S_CHK: begin
					if (lt) begin
						found_q <= 1'b1;
					end
					idx_q <= idx_q + CW'(1);
				end
				fwpi_pkg::S_TAIL: begin
					count_q   <= count_q + CW'(1);
					m_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fwpi_pkg::S_IDLE: begin
				if (accept) begin
					carry_q    <= new_e;
					new_prio_q <= new_e.prio;
					odata_q    <= '0;
					oprio_q    <= '0;
					status_q   <= fwpi_pkg::ST_DONE;
					fill_q     <= 5'(count_q);
					if ((fn == fwpi_pkg::FN_APPEND || fn == fwpi_pkg::FN_INSERT) && full) begin
						status_q <= fwpi_pkg::ST_FULL;
					end else if ((fn == fwpi_pkg::FN_APPEND || fn == fwpi_pkg::FN_INSERT)
					             && (fn == fwpi_pkg::FN_APPEND || empty)) begin
						fill_q <= 5'(count_q + CW'(1));
					end else if (fn == fwpi_pkg::FN_REMOVE && empty) begin
						status_q <= fwpi_pkg::ST_EMPTY;
					end
				end
			end
			fwpi_pkg::S_HEAD: begin
				odata_q <= rd_e.data;
				oprio_q <= rd_e.prio;
				fill_q  <= 5'(count_q - CW'(1));
			end
			fwpi_pkg::S_CHK: begin
				if (found_q || lt) begin
					carry_q <= rd_e;
				end
			end
			fwpi_pkg::S_TAIL: begin
				fill_q <= 5'(count_q + CW'(1));
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, fill_q, oprio_q, odata_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_walk_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fwpi_pkg::S_RD || state_q == fwpi_pkg::S_CHK) |-> idx_q < count_q)
		else $error("walk index past tail");
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q == fwpi_pkg::ST_EMPTY |-> fill_q == '0)
		else $error("empty flag with nonzero fill");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fwpi_pkg::S_TAIL |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow queue");
endmodule
